// ===== hw/rtl/wps_pkg.sv =====
package wps_pkg;

    // Store geometry
    localparam int PIXEL_MAX_DEF  = 256;
    localparam int BITS_PER_PIXEL = 24;
    localparam int TICK_NS        = 100;

    // Reset timing in ticks
    localparam logic [7:0] ONE_HIGH_RST  = 8'(800 / TICK_NS);
    localparam logic [7:0] ONE_LOW_RST   = 8'(450 / TICK_NS);
    localparam logic [7:0] ZERO_HIGH_RST = 8'(400 / TICK_NS);
    localparam logic [7:0] ZERO_LOW_RST  = 8'(850 / TICK_NS);

    // Command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_SHOW  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_LED_COUNT = 3'd0;
    localparam logic [2:0] REG_ONE_HIGH  = 3'd1;
    localparam logic [2:0] REG_ONE_LOW   = 3'd2;
    localparam logic [2:0] REG_ZERO_HIGH = 3'd3;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd4;

    typedef struct packed {
        logic [8:0] led_count;
        logic [7:0] one_high;
        logic [7:0] one_low;
        logic [7:0] zero_high;
        logic [7:0] zero_low;
    } t_cfg;

    // A programmed count of zero behaves as one tick
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

// ===== hw/rtl/ws2812_pixel_serializer_top.sv =====
// Serial LED strip driver with an on-chip pixel store.
// Command channel: an item (i_cmd, i_index, i_red, i_green, i_blue) is taken
// at a rising edge with i_start high and o_busy low. Commands: tick (one
// 100 ns unit of the line waveform), set pixel, show frame, clear and show.
// Every accepted item gives one result (o_line_level, o_busy_res,
// o_frame_done) on the cycle after it is taken, marked by o_strobe for one
// cycle; the receiver cannot stall and must take it then.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// o_cfg_ready is always high.
// Throughput: one item per cycle inside a pixel. An item that moves to the
// next pixel, or a show, holds o_busy high while the store's single read
// port returns that pixel.
// Reset and clear: the store is swept to zero one entry per cycle, so o_busy
// stays high while the sweep runs after reset and after each clear item.
// The result of a clear item does not wait for the sweep to end.
module ws2812_pixel_serializer_top
    import wps_pkg::*;
#(
    parameter int PIXEL_MAX = PIXEL_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_strobe,
    output logic       o_line_level,
    output logic       o_busy_res,
    output logic       o_frame_done,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);

    localparam int AW   = (PIXEL_MAX > 1) ? $clog2(PIXEL_MAX) : 1;
    localparam int CW   = $clog2(PIXEL_MAX + 1);
    localparam int CNTW = (CW > 9) ? CW : 9;

    t_cfg                      cfg;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [BITS_PER_PIXEL-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [BITS_PER_PIXEL-1:0] rd_data;

    wps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wps_pixel_mem #(
        .DEPTH (PIXEL_MAX),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    wps_ctrl #(
        .PIXEL_MAX (PIXEL_MAX),
        .AW        (AW),
        .CNTW      (CNTW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_index      (i_index),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_cfg        (cfg),
        .o_strobe     (o_strobe),
        .o_line_level (o_line_level),
        .o_busy_res   (o_busy_res),
        .o_frame_done (o_frame_done),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

endmodule

// ===== hw/rtl/wps_pixel_mem.sv =====
module wps_pixel_mem
    import wps_pkg::*;
#(
    parameter int DEPTH = PIXEL_MAX_DEF,
    parameter int AW    = 8
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [BITS_PER_PIXEL-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [BITS_PER_PIXEL-1:0] o_rd_data
);

    logic [BITS_PER_PIXEL-1:0] r_mem [DEPTH];
    logic [BITS_PER_PIXEL-1:0] r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/wps_cfg_regs.sv =====
module wps_cfg_regs
    import wps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Hold register values, update on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_count <= 9'd0;
            r_cfg.one_high  <= ONE_HIGH_RST;
            r_cfg.one_low   <= ONE_LOW_RST;
            r_cfg.zero_high <= ZERO_HIGH_RST;
            r_cfg.zero_low  <= ZERO_LOW_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_LED_COUNT: r_cfg.led_count <= i_cfg_data;
                REG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data[7:0];
                REG_ONE_LOW:   r_cfg.one_low   <= i_cfg_data[7:0];
                REG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data[7:0];
                REG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/wps_ctrl.sv =====
module wps_ctrl
    import wps_pkg::*;
#(
    parameter int PIXEL_MAX = PIXEL_MAX_DEF,
    parameter int AW        = 8,
    parameter int CNTW      = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [1:0]                i_cmd,
    input  logic [7:0]                i_index,
    input  logic [7:0]                i_red,
    input  logic [7:0]                i_green,
    input  logic [7:0]                i_blue,
    input  t_cfg                      i_cfg,
    output logic                      o_strobe,
    output logic                      o_line_level,
    output logic                      o_busy_res,
    output logic                      o_frame_done,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [BITS_PER_PIXEL-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [BITS_PER_PIXEL-1:0] i_rd_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH
    } t_state;

    localparam logic [4:0]    LAST_BIT = 5'(BITS_PER_PIXEL - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PIXEL_MAX - 1);

    t_state                    r_state,     n_state;
    logic [AW-1:0]             r_clr_addr,  n_clr_addr;
    logic                      r_clr_frame, n_clr_frame;
    logic                      r_sending,   n_sending;
    logic [CNTW-1:0]           r_ptr,       n_ptr;
    logic [4:0]                r_bitpos,    n_bitpos;
    logic                      r_low,       n_low;
    logic [7:0]                r_tick,      n_tick;
    logic [BITS_PER_PIXEL-1:0] r_word,      n_word;
    logic                      r_strobe,    n_strobe;
    logic                      r_level,     n_level;
    logic                      r_busy_res,  n_busy_res;
    logic                      r_done,      n_done;

    logic [CNTW-1:0] eff_count;
    logic [CNTW-1:0] idx_ext;
    logic [CNTW:0]   ptr_inc;
    logic            accept;
    logic            cur_bit;
    logic            prev_bit;

    // Count saturates at the store size
    assign eff_count = (CNTW'(i_cfg.led_count) > CNTW'(PIXEL_MAX)) ?
                       CNTW'(PIXEL_MAX) : CNTW'(i_cfg.led_count);
    assign idx_ext   = CNTW'(i_index);
    assign ptr_inc   = {1'b0, r_ptr} + (CNTW+1)'(1);
    assign accept    = i_start && (r_state == S_IDLE);
    assign cur_bit   = r_word[r_bitpos];
    assign prev_bit  = r_word[r_bitpos - 5'd1];

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_frame = r_clr_frame;
        n_sending   = r_sending;
        n_ptr       = r_ptr;
        n_bitpos    = r_bitpos;
        n_low       = r_low;
        n_tick      = r_tick;
        n_word      = r_word;
        n_strobe    = 1'b0;
        n_level     = 1'b0;
        n_done      = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_clr_addr;
        o_wr_data   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;

        unique case (r_state)
            // Sweep zeros through the store, then start a pending frame
            S_CLEAR: begin
                o_wr_en    = 1'b1;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_clr_addr = '0;
                    n_state    = S_IDLE;
                    if (r_clr_frame) begin
                        n_word   = '0;
                        n_ptr    = '0;
                        n_bitpos = LAST_BIT;
                        n_low    = 1'b0;
                        n_tick   = at_least_one(i_cfg.zero_high);
                    end
                    n_clr_frame = 1'b0;
                end
            end

            // Load the pixel that was read last cycle
            S_FETCH: begin
                n_word   = i_rd_data;
                n_bitpos = LAST_BIT;
                n_low    = 1'b0;
                n_tick   = at_least_one(i_rd_data[BITS_PER_PIXEL-1] ?
                                        i_cfg.one_high : i_cfg.zero_high);
                n_state  = S_IDLE;
            end

            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    if (r_sending) begin
                        n_level = !r_low;
                        if (i_cmd == CMD_TICK) begin
                            // Advance one tick of the waveform
                            priority if (r_tick > 8'd1) begin
                                n_tick = r_tick - 8'd1;
                            end else if (!r_low) begin
                                n_low  = 1'b1;
                                n_tick = at_least_one(cur_bit ?
                                                      i_cfg.one_low : i_cfg.zero_low);
                            end else if (r_bitpos != 5'd0) begin
                                n_bitpos = r_bitpos - 5'd1;
                                n_low    = 1'b0;
                                n_tick   = at_least_one(prev_bit ?
                                                        i_cfg.one_high : i_cfg.zero_high);
                            end else if (ptr_inc >= {1'b0, eff_count}) begin
                                n_sending = 1'b0;
                                n_low     = 1'b0;
                                n_tick    = 8'd0;
                                n_bitpos  = 5'd0;
                                n_ptr     = ptr_inc[CNTW-1:0];
                                n_done    = 1'b1;
                            end else begin
                                n_ptr     = ptr_inc[CNTW-1:0];
                                o_rd_en   = 1'b1;
                                o_rd_addr = ptr_inc[AW-1:0];
                                n_state   = S_FETCH;
                            end
                        end
                    end else begin
                        unique case (i_cmd)
                            CMD_TICK: ;
                            CMD_SET: begin
                                if (idx_ext < eff_count) begin
                                    o_wr_en   = 1'b1;
                                    o_wr_addr = idx_ext[AW-1:0];
                                    o_wr_data = {i_green, i_red, i_blue};
                                end
                            end
                            CMD_SHOW: begin
                                if (eff_count == '0) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_sending = 1'b1;
                                    n_ptr     = '0;
                                    o_rd_en   = 1'b1;
                                    n_state   = S_FETCH;
                                end
                            end
                            CMD_CLEAR: begin
                                n_state    = S_CLEAR;
                                n_clr_addr = '0;
                                if (eff_count == '0) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_sending   = 1'b1;
                                    n_clr_frame = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase

        n_busy_res = n_sending;
    end

    // Hold state and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_frame <= 1'b0;
            r_sending   <= 1'b0;
            r_ptr       <= '0;
            r_bitpos    <= 5'd0;
            r_low       <= 1'b0;
            r_tick      <= 8'd0;
            r_word      <= '0;
            r_strobe    <= 1'b0;
            r_level     <= 1'b0;
            r_busy_res  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_frame <= n_clr_frame;
            r_sending   <= n_sending;
            r_ptr       <= n_ptr;
            r_bitpos    <= n_bitpos;
            r_low       <= n_low;
            r_tick      <= n_tick;
            r_word      <= n_word;
            r_strobe    <= n_strobe;
            r_level     <= n_level;
            r_busy_res  <= n_busy_res;
            r_done      <= n_done;
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_line_level = r_level;
    assign o_busy_res   = r_busy_res;
    assign o_frame_done = r_done;

    // A result follows only an accepted item
    a_strobe_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_start && r_state == S_IDLE))
        else $error("result without accepted item");

    // The item that ends a frame reports the block no longer sending
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_done) |-> !r_busy_res)
        else $error("frame done while still busy");

    // The fetch state always returns to idle on the next cycle
    a_fetch_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |=> (r_state == S_IDLE))
        else $error("fetch did not return to idle");

    // Read and write never touch the store in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("store read and write overlap");

    // Bit position stays inside the pixel word
    a_bitpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bitpos <= LAST_BIT)
        else $error("bit position out of range");

endmodule

// ===== tb/tb_top.sv =====
import wps_pkg::*;

// One line sample as the block reports it for an item
typedef struct packed {
    logic level;
    logic busy;
    logic done;
} t_line_sample;

// Tracks the strip driver state and the line samples still owed by the block
class t_waveform_tracker;
    t_cfg        regs;
    logic [23:0] pixels [PIXEL_MAX_DEF];
    logic [8:0]  ptr;
    logic [4:0]  bit_pos;
    logic [7:0]  ticks_left;
    bit          in_low;
    bit          sending;
    logic [23:0] word;
    t_line_sample due[$];
    int          errors;

    function new();
        regs.led_count = '0;
        regs.one_high  = ONE_HIGH_RST;
        regs.one_low   = ONE_LOW_RST;
        regs.zero_high = ZERO_HIGH_RST;
        regs.zero_low  = ZERO_LOW_RST;
        foreach (pixels[i]) pixels[i] = '0;
        ptr        = '0;
        bit_pos    = '0;
        ticks_left = '0;
        in_low     = 0;
        sending    = 0;
        word       = '0;
        errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [8:0] data);
        case (idx)
            REG_LED_COUNT: regs.led_count = data;
            REG_ONE_HIGH:  regs.one_high  = data[7:0];
            REG_ONE_LOW:   regs.one_low   = data[7:0];
            REG_ZERO_HIGH: regs.zero_high = data[7:0];
            REG_ZERO_LOW:  regs.zero_low  = data[7:0];
            default: ;
        endcase
    endfunction

    // Pixels per frame, clipped to the store size
    function int frame_len();
        if (regs.led_count > 9'(PIXEL_MAX_DEF)) return PIXEL_MAX_DEF;
        return int'(regs.led_count);
    endfunction

    // Phase length of the current bit; a zero count lasts one tick
    function logic [7:0] phase_ticks(bit low_ph);
        logic [7:0] t;
        if (word[bit_pos]) t = low_ph ? regs.one_low : regs.one_high;
        else               t = low_ph ? regs.zero_low : regs.zero_high;
        return (t == 8'd0) ? 8'd1 : t;
    endfunction

    function void load_phase(bit low_ph);
        in_low     = low_ph;
        ticks_left = phase_ticks(low_ph);
    endfunction

    // Returns 1 when the frame is empty and so already over
    function bit begin_frame();
        if (frame_len() == 0) begin
            sending = 0;
            return 1;
        end
        sending = 1;
        ptr     = '0;
        word    = pixels[0];
        bit_pos = 5'd23;
        load_phase(0);
        return 0;
    endfunction

    // Run one tick of the waveform; returns 1 on the tick that ends the frame
    function bit advance();
        if (ticks_left > 8'd1) begin
            ticks_left--;
            return 0;
        end
        if (!in_low) begin
            load_phase(1);
            return 0;
        end
        if (bit_pos > 5'd0) begin
            bit_pos--;
            load_phase(0);
            return 0;
        end
        if (int'(ptr) + 1 >= frame_len()) begin
            sending    = 0;
            in_low     = 0;
            ticks_left = '0;
            bit_pos    = '0;
            ptr        = ptr + 9'd1;
            return 1;
        end
        ptr++;
        word    = pixels[ptr[7:0]];
        bit_pos = 5'd23;
        load_phase(0);
        return 0;
    endfunction

    // Apply one accepted item; returns 0 when the block just drops it
    function bit note_item(logic [1:0] cmd, logic [7:0] idx,
                           logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        t_line_sample s;
        bit acted;
        s = '0;
        acted = 1;
        if (sending) begin
            s.level = !in_low;
            if (cmd == CMD_TICK) s.done = advance();
            else acted = 0;
        end else begin
            case (cmd)
                CMD_SET: begin
                    if (int'(idx) < frame_len()) pixels[idx] = {green, red, blue};
                    else acted = 0;
                end
                CMD_SHOW: s.done = begin_frame();
                CMD_CLEAR: begin
                    foreach (pixels[i]) pixels[i] = '0;
                    s.done = begin_frame();
                end
                default: acted = 0;
            endcase
        end
        s.busy = sending;
        due.push_back(s);
        return acted;
    endfunction

    function void flag(string what, logic want, logic got);
        errors++;
        if (errors <= 10) $display("mismatch on %s: expected %b, got %b", what, want, got);
    endfunction

    // Compare a reported sample with the oldest one owed
    function void check_sample(logic level, logic busy, logic done);
        t_line_sample want;
        if (due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("sample with no item pending: %b %b %b", level, busy, done);
            return;
        end
        want = due.pop_front();
        if (want.level !== level) flag("line_level", want.level, level);
        if (want.busy !== busy) flag("busy_res", want.busy, busy);
        if (want.done !== done) flag("frame_done", want.done, done);
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_GOAL   = 1700;
    localparam int TAIL_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    logic       o_busy;
    logic [1:0] i_cmd;
    logic [7:0] i_index;
    logic [7:0] i_red;
    logic [7:0] i_green;
    logic [7:0] i_blue;
    logic       o_strobe;
    logic       o_line_level;
    logic       o_busy_res;
    logic       o_frame_done;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [8:0] i_cfg_data;

    t_waveform_tracker book;
    int  live_items;
    int  idle_cycles = 0;
    bit  steady;

    logic [1:0] all_cmds [4]  = '{CMD_TICK, CMD_SET, CMD_SHOW, CMD_CLEAR};
    logic [1:0] busy_cmds [3] = '{CMD_SET, CMD_SHOW, CMD_CLEAR};

    ws2812_pixel_serializer_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Check every reported sample against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) book.check_sample(o_line_level, o_busy_res, o_frame_done);
    end

    // Stop a run that no longer moves items
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one item, hold it until taken, then now and then idle a while
    task automatic send(input logic [1:0] cmd, input logic [7:0] idx,
                        input logic [7:0] red, input logic [7:0] green,
                        input logic [7:0] blue);
        int gap;
        i_start <= 1'b1;
        i_cmd   <= cmd;
        i_index <= idx;
        i_red   <= red;
        i_green <= green;
        i_blue  <= blue;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        void'(book.note_item(cmd, idx, red, green, blue));
        live_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_rand(input logic [1:0] cmd);
        send(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // Drop start and hold until every owed sample is back and the block is idle
    task automatic drain();
        i_start <= 1'b0;
        do @(posedge i_clk); while (book.due.size() != 0 || o_busy);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        book.write_reg(idx, data);
    endtask

    task automatic release_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [8:0] cnt, input logic [8:0] oh, input logic [8:0] ol,
                             input logic [8:0] zh, input logic [8:0] zl);
        write_reg(REG_LED_COUNT, cnt);
        write_reg(REG_ONE_HIGH, oh);
        write_reg(REG_ONE_LOW, ol);
        write_reg(REG_ZERO_HIGH, zh);
        write_reg(REG_ZERO_LOW, zl);
        release_cfg();
    endtask

    task automatic finish_frame();
        while (book.sending) send_rand(CMD_TICK);
    endtask

    // Pick line timing and strip length; long bits go with at most one pixel
    task automatic random_settings();
        logic [7:0] t [4];
        logic [8:0] cnt;
        bit slow;
        int roll;
        slow = 0;
        foreach (t[k]) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)      t[k] = 8'($urandom_range(0, 3));
            else if (roll < 95) t[k] = 8'($urandom_range(4, 12));
            else                t[k] = 8'($urandom_range(13, 24));
            if (t[k] > 8'd12) slow = 1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 10)      cnt = 9'd0;
        else if (roll < 85) cnt = 9'($urandom_range(1, 3));
        else                cnt = 9'($urandom_range(4, 8));
        if (slow) cnt = 9'($urandom_range(0, 1));
        write_all(cnt, {1'($urandom_range(0, 1)), t[0]}, {1'($urandom_range(0, 1)), t[1]},
                  {1'($urandom_range(0, 1)), t[2]}, {1'($urandom_range(0, 1)), t[3]});
    endtask

    function automatic logic [7:0] rand_index();
        if (book.frame_len() > 0 && $urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, book.frame_len() - 1));
        return 8'($urandom);
    endfunction

    // Load some pixels, start a frame and tick it out, with stray commands mixed in
    task automatic random_frame();
        repeat ($urandom_range(0, 5)) begin
            send(CMD_SET, rand_index(), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        send_rand(($urandom_range(0, 9) == 0) ? CMD_CLEAR : CMD_SHOW);
        while (book.sending) begin
            if ($urandom_range(0, 24) == 0) send_rand(busy_cmds[$urandom_range(0, 2)]);
            else send_rand(CMD_TICK);
            // shorten the strip under a running frame now and then
            if ($urandom_range(0, 399) == 0) begin
                drain();
                write_reg(REG_LED_COUNT, 9'($urandom_range(0, 3)));
                release_cfg();
            end
        end
    endtask

    initial begin
        book        = new();
        live_items  = 0;
        steady      = 0;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_cmd       <= CMD_TICK;
        i_index     <= '0;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_LED_COUNT;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle line with reset settings, empty strip
        send(CMD_TICK, 8'hff, 8'hff, 8'hff, 8'hff);
        send(CMD_SET, 8'h00, 8'h12, 8'h34, 8'h56);
        send(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        send(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        drain();

        // one pixel at reset timing; out-of-range and busy items are dropped
        write_reg(REG_LED_COUNT, 9'd1);
        release_cfg();
        send(CMD_SET, 8'd0, 8'h00, 8'hff, 8'ha5);
        send(CMD_SET, 8'd1, 8'hff, 8'h00, 8'h5a);
        send(CMD_SET, 8'hff, 8'hff, 8'hff, 8'hff);
        send(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        send(CMD_SET, 8'd0, 8'h11, 8'h22, 8'h33);
        send(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        send(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();
        drain();

        // lower the count once the frame is past the first pixel
        write_all(9'd3, 9'd1, 9'd2, 9'd3, 9'd1);
        send(CMD_SET, 8'd2, 8'h3c, 8'hc3, 8'h0f);
        send(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        while (book.sending && book.ptr == 9'd0) send_rand(CMD_TICK);
        drain();
        write_reg(REG_LED_COUNT, 9'd1);
        release_cfg();
        finish_frame();
        drain();

        // clear wipes the store and sends a dark pixel
        write_reg(REG_LED_COUNT, 9'd1);
        release_cfg();
        send(CMD_SET, 8'd0, 8'hf0, 8'h0f, 8'h99);
        send(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();
        drain();

        // oversized count saturates to the full store, zero timing acts as one tick;
        // shorten the strip after a few pixels
        write_all(9'h1ff, 9'd0, 9'd0, 9'd0, 9'd0);
        send(CMD_SET, 8'hff, 8'ha5, 8'h5a, 8'hc3);
        send(CMD_SET, 8'd0, 8'hff, 8'hff, 8'hff);
        send(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        while (book.sending && book.ptr < 9'd2) send_rand(CMD_TICK);
        drain();
        write_reg(REG_LED_COUNT, 9'd1);
        release_cfg();
        finish_frame();
        drain();

        // longest high phase on a single one bit
        write_all(9'd1, 9'h1ff, 9'd1, 9'd1, 9'd1);
        send(CMD_SET, 8'd0, 8'h00, 8'h00, 8'h01);
        send(CMD_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        finish_frame();

        // random phases: fresh settings, noise, then well-formed frames
        while (live_items < ITEM_GOAL) begin
            finish_frame();
            drain();
            random_settings();
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                if (live_items >= ITEM_GOAL) break;
                repeat ($urandom_range(0, 3)) send_rand(all_cmds[$urandom_range(0, 3)]);
                random_frame();
            end
        end

        finish_frame();
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.errors == 0 && book.due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
